FILE: sv/ple_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine: action and status
// codes, field widths and the command word broadcast to the list cells.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ACT_W = 2;
    localparam int ST_W  = 2;

    // action carried with each input word
    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

    // status returned with each result word
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // operation applied by every cell together
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_INS  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_READ = 3'd3,
        CELL_FIND = 3'd4
    } cell_op_t;

    // command broadcast along the chain
    typedef struct packed {
        cell_op_t               op;
        logic [POS_W-1:0]       slot;   // zero-based target position
        logic [POS_W-1:0]       count;  // entries held before the operation
        logic [VAL_W-1:0]       value;  // value to insert or key to match
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: sv/ple_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds a value, takes its neighbor's value on an insert or
// delete shift, and flags a key match or a read hit for the chain.
// ----------------------------------------------------------------------------
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              aclk,
    input  wire cell_cmd_t         cmd,
    input  wire logic [VAL_W-1:0]  left_value,
    input  wire logic [VAL_W-1:0]  right_value,
    output logic      [VAL_W-1:0]  value,
    output logic                   match,
    output logic      [VAL_W-1:0]  read_term
);

    localparam logic [POS_W-1:0] IDX_POS = POS_W'(IDX);

    logic [VAL_W-1:0] value_reg;
    logic             match_reg;
    logic [VAL_W-1:0] read_reg;

    // slot contents: shift up on insert, shift down on delete
    always_ff @(posedge aclk) begin
        case (cmd.op)
            CELL_INS: begin
                if (IDX_POS > cmd.slot) begin
                    value_reg <= left_value;
                end else if (IDX_POS == cmd.slot) begin
                    value_reg <= cmd.value;
                end
            end
            CELL_DEL: begin
                if (IDX_POS >= cmd.slot) begin
                    value_reg <= right_value;
                end
            end
            default: begin
                value_reg <= value_reg;
            end
        endcase
    end

    // match flag for live entries and gated read term
    always_ff @(posedge aclk) begin
        match_reg <= (cmd.op == CELL_FIND) && (IDX_POS < cmd.count) &&
                     (value_reg == cmd.value);
        read_reg  <= ((cmd.op == CELL_READ) && (IDX_POS == cmd.slot)) ?
                     value_reg : '0;
    end

    assign value     = value_reg;
    assign match     = match_reg;
    assign read_term = read_reg;

endmodule
`default_nettype wire

FILE: sv/ple_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_chain
// Row of list cells wired to their neighbors, with the merge of the read
// terms and the first-match encoder over the cell match flags.
// ----------------------------------------------------------------------------
module ple_chain
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic              aclk,
    input  wire cell_cmd_t         cmd,
    output logic      [VAL_W-1:0]  read_value,
    output logic                   found,
    output logic      [POS_W-1:0]  found_position
);

    logic [VAL_W-1:0]    cell_value [CAPACITY];
    logic [VAL_W-1:0]    cell_read  [CAPACITY];
    logic [CAPACITY-1:0] cell_match;

    // cells, each linked to both neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] left_value;
        logic [VAL_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_left
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_right
            assign right_value = cell_value[g+1];
        end

        ple_cell #(
            .IDX (g)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g]),
            .match       (cell_match[g]),
            .read_term   (cell_read[g])
        );
    end

    // only the addressed cell drives a nonzero read term
    always_comb begin
        read_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_value = read_value | cell_read[i];
        end
    end

    // lowest matching cell wins, reported 1-based
    always_comb begin
        found_position = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (cell_match[i]) begin
                found_position = POS_W'(i + 1);
            end
        end
    end

    assign found = |cell_match;

endmodule
`default_nettype wire

FILE: sv/positional_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with 1-based positions, held in a row
// of cells. Insert, delete, read and find, one result word per input word.
//
//   channel  dir  tdata (lsb first)                           tuser
//   s_axis   in   position[5:0], value[37:6], pad              action
//   m_axis   out  read_value[31:0], found_position[37:32],     status
//                 entry_count[43:38], is_empty[44], pad
//
// Each word passes through S_IDLE, in which it is accepted, S_EXEC, in which
// all cells shift, compare or read together, S_PACK, which merges the read
// terms and encodes the first match into the result register, and S_OUT, in
// which the result word is offered and taken.
// One word is in flight at a time; s_axis_tready returns the cycle after the
// result is taken, so a stalled m_axis holds the input side off.
// Reset clears the state and the entry count only; slot contents are never read unwritten.
// ----------------------------------------------------------------------------
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position, value, pad
    input  wire logic [1:0]  s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [47:0] m_axis_tdata,   // read_value, found_position,
                                             // entry_count, is_empty, pad
    output logic      [1:0]  m_axis_tuser    // status
);

    localparam logic [POS_W-1:0] CAP_CNT = POS_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_PACK = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    action_t           act_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [POS_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;
    status_t           out_status_reg;
    logic [VAL_W-1:0]  out_read_reg;
    logic [POS_W-1:0]  out_found_reg;
    logic [POS_W-1:0]  out_count_reg;
    logic              out_empty_reg;

    cell_cmd_t         cmd;
    logic [VAL_W-1:0]  chain_read;
    logic              chain_found;
    logic [POS_W-1:0]  chain_pos;
    logic              in_fire;
    logic              out_fire;
    logic              ins_pos_ok;
    logic              pos_ok;
    logic [POS_W:0]    count_plus1;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // position checks against the count before the operation
    assign count_plus1 = {1'b0, count_reg} + (POS_W+1)'(1);
    assign ins_pos_ok  = (pos_reg != '0) && ({1'b0, pos_reg} <= count_plus1);
    assign pos_ok      = (pos_reg != '0) && (pos_reg <= count_reg);

    // command to the cells, status and new count
    always_comb begin
        cmd.op      = CELL_HOLD;
        cmd.slot    = pos_reg - POS_W'(1);
        cmd.count   = count_reg;
        cmd.value   = val_reg;
        status_next = status_reg;
        count_next  = count_reg;
        if (state_reg == S_EXEC) begin
            case (act_reg)
                ACT_INSERT: begin
                    if (!ins_pos_ok) begin
                        status_next = ST_BADPOS;
                    end else if (count_reg >= CAP_CNT) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_OK;
                        cmd.op      = CELL_INS;
                        count_next  = count_reg + POS_W'(1);
                    end
                end
                ACT_DELETE: begin
                    if (!pos_ok) begin
                        status_next = ST_BADPOS;
                    end else begin
                        status_next = ST_OK;
                        cmd.op      = CELL_DEL;
                        count_next  = count_reg - POS_W'(1);
                    end
                end
                ACT_READ: begin
                    status_next = pos_ok ? ST_OK : ST_BADPOS;
                    cmd.op      = CELL_READ;
                end
                ACT_FIND: begin
                    status_next = ST_NOTFOUND;
                    cmd.op      = CELL_FIND;
                end
                default: begin
                    status_next = ST_BADPOS;
                end
            endcase
        end
    end

    ple_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk           (aclk),
        .cmd            (cmd),
        .read_value     (chain_read),
        .found          (chain_found),
        .found_position (chain_pos)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_EXEC;
            S_EXEC:  state_next = S_PACK;
            S_PACK:  state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // capture the input word
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            act_reg <= action_t'(s_axis_tuser);
            pos_reg <= s_axis_tdata[POS_W-1:0];
            val_reg <= s_axis_tdata[POS_W+VAL_W-1:POS_W];
        end
        status_reg <= status_next;
    end

    // result word
    always_ff @(posedge aclk) begin
        if (state_reg == S_PACK) begin
            out_count_reg <= count_reg;
            out_empty_reg <= (count_reg == '0);
            out_read_reg  <= '1;
            out_found_reg <= '0;
            out_status_reg <= status_reg;
            if (act_reg == ACT_FIND) begin
                if (chain_found) begin
                    out_status_reg <= ST_OK;
                    out_found_reg  <= chain_pos;
                end
            end else if ((act_reg == ACT_READ) && (status_reg == ST_OK)) begin
                out_read_reg <= chain_read;
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_empty_reg, out_count_reg, out_found_reg,
                            out_read_reg};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted word not executed");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == ST_FULL)) |->
        (out_count_reg == CAP_CNT))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> $stable(count_reg))
        else $error("count changed outside execute");

endmodule
`default_nettype wire

FILE: tb/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts each result word at the moment its input word is accepted.
// A monitor compares every result word, field by field, with the oldest
// prediction. Traffic runs through these phases in order:
//   - directed bound and edge cases
//   - fill to capacity and drain
//   - a long random mix with bursty idling on both sides
//   - a long output hold-off
//   - a back-to-back stretch with no idling
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int LONG_HOLD   = 200;
    localparam int CYCLE_LIMIT = 400000;

    // one predicted result word
    typedef struct {
        status_t     status;
        logic [31:0] read_value;
        logic [5:0]  found_pos;
        logic [5:0]  entry_count;
        logic        is_empty;
    } list_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // position[5:0], value[37:6], pad
    logic [1:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_value[31:0], found_position[37:32],
                                 // entry_count[43:38], is_empty[44], pad
    logic [1:0]  m_axis_tuser;   // status

    logic [31:0]  list_image[$];
    list_result_t pending_results[$];
    int           err_count;
    int           cycle_count;
    bit           src_gaps_on;
    bit           sink_stalls_on;
    bit           hold_request;

    positional_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock, period 8
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(string msg);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // apply one accepted word to the shadow list and queue its result
    function automatic void predict_result(action_t act, logic [5:0] pos, logic [31:0] val);
        list_result_t r;
        int n;
        int p;
        n = list_image.size();
        p = int'(pos);
        r.status     = ST_OK;
        r.read_value = '1;
        r.found_pos  = '0;
        case (act)
            ACT_INSERT: begin
                if (p < 1 || p > n + 1)
                    r.status = ST_BADPOS;
                else if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                    list_image.insert(p - 1, val);
            end
            ACT_DELETE: begin
                if (p < 1 || p > n)
                    r.status = ST_BADPOS;
                else
                    list_image.delete(p - 1);
            end
            ACT_READ: begin
                if (p < 1 || p > n)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_image[p - 1];
            end
            default: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (list_image[i] == val) begin
                        r.status    = ST_OK;
                        r.found_pos = 6'(i + 1);
                        break;
                    end
                end
            end
        endcase
        r.entry_count = 6'(list_image.size());
        r.is_empty    = (list_image.size() == 0);
        pending_results.push_back(r);
    endfunction

    // offer one word, optionally after an idle burst; returns at a falling edge
    task automatic send_word(action_t act, logic [5:0] pos, logic [31:0] val);
        if (src_gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {2'b00, val, pos};
        s_axis_tuser  = act;
        do @(posedge aclk); while (!s_axis_tready);
        predict_result(act, pos, val);
        @(negedge aclk);
    endtask

    // values biased toward duplicates and the signed extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 7);
            1:       return 32'h8000_0000 | $urandom_range(0, 3);
            2:       return 32'h7fff_fffc | $urandom_range(0, 3);
            3:       return 32'hffff_fffc | $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result monitor
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word, tuser %0d tdata %h",
                                        m_axis_tuser, m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            m_axis_tuser, want.status));
                if (m_axis_tdata[31:0] !== want.read_value)
                    flag_mismatch($sformatf("read_value %h, want %h",
                                            m_axis_tdata[31:0], want.read_value));
                if (m_axis_tdata[37:32] !== want.found_pos)
                    flag_mismatch($sformatf("found_position %0d, want %0d",
                                            m_axis_tdata[37:32], want.found_pos));
                if (m_axis_tdata[43:38] !== want.entry_count)
                    flag_mismatch($sformatf("entry_count %0d, want %0d",
                                            m_axis_tdata[43:38], want.entry_count));
                if (m_axis_tdata[44] !== want.is_empty)
                    flag_mismatch($sformatf("is_empty %b, want %b",
                                            m_axis_tdata[44], want.is_empty));
            end
        end
    end

    // result side ready: random stall bursts, plus one long hold on request
    initial begin : sink_ready
        int held;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_axis_tready = 1'b0;
                held = 0;
                while (held < LONG_HOLD) begin
                    @(negedge aclk);
                    held++;
                end
                m_axis_tready = 1'b1;
                hold_request  = 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // bounds on an empty and a short list, extremes, head middle and tail
    task automatic test_bounds_and_edges();
        send_word(ACT_READ,   6'd1,  32'd0);
        send_word(ACT_DELETE, 6'd1,  32'd0);
        send_word(ACT_FIND,   6'd0,  32'd0);
        send_word(ACT_INSERT, 6'd0,  32'd5);
        send_word(ACT_INSERT, 6'd2,  32'd5);
        send_word(ACT_INSERT, 6'd1,  32'h7fff_ffff);
        send_word(ACT_INSERT, 6'd1,  32'h8000_0000);
        send_word(ACT_INSERT, 6'd3,  32'hffff_ffff);
        send_word(ACT_INSERT, 6'd2,  32'd0);
        send_word(ACT_INSERT, 6'd63, 32'd1);
        send_word(ACT_READ,   6'd1,  32'd0);
        send_word(ACT_READ,   6'd2,  32'd0);
        send_word(ACT_READ,   6'd3,  32'd0);
        send_word(ACT_READ,   6'd4,  32'd0);
        send_word(ACT_READ,   6'd5,  32'd0);
        send_word(ACT_READ,   6'd63, 32'd0);
        send_word(ACT_FIND,   6'd63, 32'hffff_ffff);
        send_word(ACT_FIND,   6'd0,  32'h8000_0000);
        send_word(ACT_FIND,   6'd0,  32'd12345);
        send_word(ACT_DELETE, 6'd63, 32'd0);
        send_word(ACT_DELETE, 6'd2,  32'd0);
        send_word(ACT_DELETE, 6'd1,  32'd0);
        send_word(ACT_DELETE, 6'd2,  32'd0);
        send_word(ACT_DELETE, 6'd1,  32'd0);
        send_word(ACT_FIND,   6'd0,  32'h7fff_ffff);
    endtask

    // fill to capacity, probe the full list, then drain it
    task automatic test_fill_to_capacity();
        while (list_image.size() < CAPACITY)
            send_word(ACT_INSERT, 6'($urandom_range(1, list_image.size() + 1)),
                      pick_value());
        send_word(ACT_INSERT, 6'(CAPACITY + 1), 32'd7);
        send_word(ACT_INSERT, 6'd1,             32'd7);
        send_word(ACT_INSERT, 6'd0,             32'd7);
        send_word(ACT_INSERT, 6'(CAPACITY + 2), 32'd7);
        send_word(ACT_READ,   6'(CAPACITY),     32'd0);
        send_word(ACT_READ,   6'(CAPACITY + 1), 32'd0);
        send_word(ACT_FIND,   6'd0,             list_image[CAPACITY - 1]);
        while (list_image.size() > 0)
            send_word(ACT_DELETE, 6'($urandom_range(1, list_image.size())), 32'd0);
    endtask

    // mostly well-formed operations, some noise, growth and shrink phases
    task automatic test_random_mix(int n_items);
        int      r;
        int      n;
        bit      grow;
        action_t act;
        logic [5:0]  pos;
        logic [31:0] val;
        grow = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (k % 60 == 59)
                grow = !grow;
            n   = list_image.size();
            r   = $urandom_range(0, 99);
            val = pick_value();
            if (r < 8) begin
                act = action_t'($urandom_range(0, 3));
                pos = 6'($urandom_range(0, 63));
                val = $urandom();
            end else begin
                r = $urandom_range(0, 99);
                if (r < (grow ? 45 : 20))
                    act = ACT_INSERT;
                else if (r < 60)
                    act = ACT_DELETE;
                else if (r < 80)
                    act = ACT_READ;
                else
                    act = ACT_FIND;
                case (act)
                    ACT_INSERT: pos = 6'($urandom_range(1, n + 1));
                    ACT_FIND: begin
                        pos = 6'($urandom_range(0, 63));
                        if (n > 0 && $urandom_range(0, 2) != 0)
                            val = list_image[$urandom_range(0, n - 1)];
                    end
                    default: pos = (n == 0) ? 6'd1 : 6'($urandom_range(1, n));
                endcase
            end
            send_word(act, pos, val);
        end
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_hold_off();
        hold_request = 1'b1;
        for (int k = 0; k < 10; k++)
            send_word(ACT_INSERT, 6'd1, pick_value());
        while (hold_request) @(negedge aclk);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        err_count      = 0;
        cycle_count    = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        hold_request   = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_bounds_and_edges();
        test_fill_to_capacity();
        test_random_mix(750);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        test_output_hold_off();
        test_random_mix(150);
        s_axis_tvalid = 1'b0;

        wait_drained();
        repeat (16) @(posedge aclk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
